// ===== src/tcc_pkg.sv =====
// Types, constants and the CORDIC arctangent table shared by the compass modules.
// No dependencies.
package tcc_pkg;

    localparam int TabLen = 24;
    localparam logic [31:0] InvGainQ30 = 32'd652032874;
    localparam logic [31:0] UnitsPerDeg = 32'd11930465;

    function automatic logic [31:0] atan_tab(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0: v = 32'h20000000;
                5'd1: v = 32'h12E4051D;
                5'd2: v = 32'h09FB385B;
                5'd3: v = 32'h051111D4;
                5'd4: v = 32'h028B0D43;
                5'd5: v = 32'h0145D7E1;
                5'd6: v = 32'h00A2F61E;
                5'd7: v = 32'h00517C55;
                5'd8: v = 32'h0028BE53;
                5'd9: v = 32'h00145F2E;
                5'd10: v = 32'h000A2F98;
                5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;
                5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2F9;
                5'd15: v = 32'h0000517C;
                5'd16: v = 32'h000028BE;
                5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A2F;
                5'd19: v = 32'h00000517;
                5'd20: v = 32'h0000028B;
                5'd21: v = 32'h00000145;
                5'd22: v = 32'h000000A2;
                5'd23: v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // latch sample
        OP_SQ_INIT,   // start isqrt for pitch or roll
        OP_SQ_STEP,
        OP_VEC_INIT,  // start atan2
        OP_VEC_STEP,
        OP_TILT_DONE, // degrees from atan2 result
        OP_ROT_INIT,  // start sin/cos
        OP_ROT_STEP,
        OP_ROT_DONE,
        OP_MUL,       // one product step
        OP_HEAD_INIT,
        OP_HEAD_DONE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       sel;   // 0 = pitch, 1 = roll
        logic [2:0] mstep; // product step index
    } cmd_t;

    typedef struct packed {
        logic sq_done;
        logic cordic_done;
    } status_t;

    localparam logic [0:0] CmdSample = 1'b0;
    localparam logic [0:0] CmdZero   = 1'b1;
    localparam logic [0:0] RegPitchTrim = 1'b0;
    localparam logic [0:0] RegRollTrim  = 1'b1;

endpackage

// ===== src/tcc_datapath.sv =====
// Compass datapath: shared isqrt, shared CORDIC, product sequencer and state.
// Depends on tcc_pkg.
module tcc_datapath import tcc_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] mag_x,
    input  logic signed [15:0] mag_y,
    input  logic signed [15:0] mag_z,
    input  logic               zero_heading,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic signed [8:0]  pitch_deg,
    output logic signed [8:0]  roll_deg,
    output logic signed [15:0] heading
);

    localparam int Steps = (CORDIC_STEPS > TabLen) ? TabLen : CORDIC_STEPS;

    logic signed [15:0] ax_reg, ay_reg, az_reg, mx_reg, my_reg, mz_reg;
    logic signed [15:0] pitch_trim_reg, roll_trim_reg;
    logic signed [8:0]  last_pitch_reg, last_roll_reg, new_pitch_reg, new_roll_reg;
    logic [15:0]        last_heading_reg, heading_offset_reg, heading_reg;

    // isqrt: 48-bit radicand, two bits a step
    logic [47:0] sq_n_reg, sq_r_reg, sq_bit_reg;
    logic [47:0] sq_rb;
    assign sq_rb = sq_r_reg + sq_bit_reg;

    logic signed [31:0] sq_a, sq_b;
    logic [31:0]        sq_sum;
    assign sq_a   = 32'(cmd.sel ? ax_reg : ay_reg) * 32'(cmd.sel ? ax_reg : ay_reg);
    assign sq_b   = 32'(az_reg) * 32'(az_reg);
    assign sq_sum = $unsigned(sq_a) + $unsigned(sq_b);

    // CORDIC
    logic signed [47:0] cx_reg, cy_reg;
    logic [31:0]        cz_reg;
    logic [4:0]         ci_reg;
    logic               crot_reg, cflip_reg;
    logic signed [47:0] sx, sy;
    assign sx = cx_reg >>> ci_reg;
    assign sy = cy_reg >>> ci_reg;

    // sin/cos results, Q30
    logic signed [31:0] cp_reg, sp_reg, cr_reg, sr_reg;
    // products
    logic signed [63:0] prod_reg, xh_reg, yh_reg;
    logic signed [31:0] ma;
    logic signed [31:0] mb;
    logic signed [63:0] mres;
    logic signed [31:0] srsp_reg, srcp_reg;
    assign mres = ma * mb;

    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.mstep)
            3'd0: begin ma = sr_reg; mb = sp_reg; end
            3'd1: begin ma = sr_reg; mb = cp_reg; end
            3'd2: begin ma = 32'(mx_reg); mb = cp_reg; end
            3'd3: begin ma = 32'(mz_reg); mb = sp_reg; end
            3'd4: begin ma = 32'(mx_reg); mb = srsp_reg; end
            3'd5: begin ma = 32'(my_reg); mb = cr_reg; end
            3'd6: begin ma = 32'(mz_reg); mb = srcp_reg; end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    // tilt degrees from CORDIC angle
    logic signed [15:0] bau;
    logic signed [17:0] v, m;
    logic [23:0]        dd;
    logic [8:0]         dsat;
    logic signed [8:0]  dfin;
    logic [31:0]        zr;
    assign zr  = cz_reg + 32'h8000;
    assign bau = cflip_reg ? 16'sd0 : $signed(zr[31:16]);
    always_comb begin
        v    = 18'(bau) - 18'(cmd.sel ? roll_trim_reg : pitch_trim_reg);
        m    = v[17] ? -v : v;
        dd   = (24'(m) * 24'd45 + 24'd4096) >> 13;
        dsat = (dd > 24'd180) ? 9'd180 : dd[8:0];
        dfin = v[17] ? -$signed(dsat) : $signed(dsat);
    end

    logic [31:0] zdeg;
    assign zdeg = 32'(cmd.sel ? last_roll_reg : last_pitch_reg) * UnitsPerDeg;

    logic signed [47:0] vy0, vx0;
    always_comb begin
        vx0 = '0;
        vy0 = '0;
        case (cmd.op)
            OP_VEC_INIT: begin
                if (cmd.mstep == 3'd7) begin
                    vx0 = 48'(xh_reg >>> 14);
                    vy0 = 48'(-(yh_reg >>> 14));
                end else begin
                    vx0 = 48'(sq_r_reg);
                    vy0 = 48'(cmd.sel ? ay_reg : ax_reg) <<< 8;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_trim_reg     <= '0;
            roll_trim_reg      <= '0;
            last_pitch_reg     <= '0;
            last_roll_reg      <= '0;
            last_heading_reg   <= '0;
            heading_offset_reg <= '0;
            ci_reg             <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == RegPitchTrim) pitch_trim_reg <= cfg_data;
                else roll_trim_reg <= cfg_data;
            end
            if (zero_heading) heading_offset_reg <= last_heading_reg;
            case (cmd.op)
                OP_LOAD: begin
                    ax_reg <= accel_x; ay_reg <= accel_y; az_reg <= accel_z;
                    mx_reg <= mag_x;   my_reg <= mag_y;   mz_reg <= mag_z;
                end
                OP_SQ_INIT: begin
                    sq_n_reg   <= {sq_sum, 16'h0000};
                    sq_r_reg   <= '0;
                    sq_bit_reg <= 48'h4000_0000_0000;
                end
                OP_SQ_STEP: begin
                    if (sq_n_reg >= sq_rb) begin
                        sq_n_reg <= sq_n_reg - sq_rb;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end else begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
                OP_VEC_INIT: begin
                    crot_reg <= 1'b0;
                    ci_reg   <= '0;
                    if (vx0 < 0) begin
                        cx_reg <= -vx0; cy_reg <= -vy0; cz_reg <= 32'h8000_0000;
                    end else begin
                        cx_reg <= vx0;  cy_reg <= vy0;  cz_reg <= '0;
                    end
                    cflip_reg <= (vx0 == 0) && (vy0 == 0);
                end
                OP_ROT_INIT: begin
                    crot_reg  <= 1'b1;
                    ci_reg    <= '0;
                    cflip_reg <= (zdeg[31:30] == 2'd1) || (zdeg[31:30] == 2'd2);
                    cz_reg    <= ((zdeg[31:30] == 2'd1) || (zdeg[31:30] == 2'd2))
                                 ? zdeg - 32'h8000_0000 : zdeg;
                    cx_reg    <= 48'(InvGainQ30);
                    cy_reg    <= '0;
                end
                OP_VEC_STEP, OP_ROT_STEP: begin
                    if (crot_reg ? !cz_reg[31] : !cy_reg[47]) begin
                        cx_reg <= crot_reg ? cx_reg - sy : cx_reg + sy;
                        cy_reg <= crot_reg ? cy_reg + sx : cy_reg - sx;
                        cz_reg <= crot_reg ? cz_reg - atan_tab(ci_reg)
                                           : cz_reg + atan_tab(ci_reg);
                    end else begin
                        cx_reg <= crot_reg ? cx_reg + sy : cx_reg - sy;
                        cy_reg <= crot_reg ? cy_reg - sx : cy_reg + sx;
                        cz_reg <= crot_reg ? cz_reg + atan_tab(ci_reg)
                                           : cz_reg - atan_tab(ci_reg);
                    end
                    ci_reg <= ci_reg + 5'd1;
                end
                OP_TILT_DONE: begin
                    if (cflip_reg) cz_reg <= '0;
                    if (cmd.sel) new_roll_reg <= dfin;
                    else new_pitch_reg <= dfin;
                end
                OP_ROT_DONE: begin
                    if (cmd.sel) begin
                        cr_reg <= cflip_reg ? -cx_reg[31:0] : cx_reg[31:0];
                        sr_reg <= cflip_reg ? -cy_reg[31:0] : cy_reg[31:0];
                    end else begin
                        cp_reg <= cflip_reg ? -cx_reg[31:0] : cx_reg[31:0];
                        sp_reg <= cflip_reg ? -cy_reg[31:0] : cy_reg[31:0];
                    end
                end
                OP_MUL: begin
                    prod_reg <= mres;
                    case (cmd.mstep)
                        3'd1: srsp_reg <= prod_reg[61:30];
                        3'd2: srcp_reg <= prod_reg[61:30];
                        3'd3: xh_reg <= prod_reg;
                        3'd4: xh_reg <= xh_reg + prod_reg;
                        3'd5: yh_reg <= prod_reg;
                        3'd6: yh_reg <= yh_reg + prod_reg;
                        default: ;
                    endcase
                end
                OP_HEAD_INIT: yh_reg <= yh_reg - prod_reg;
                OP_HEAD_DONE: begin
                    heading_reg      <= (cflip_reg ? 16'd0 : bau) - heading_offset_reg;
                    last_heading_reg <= cflip_reg ? 16'd0 : bau;
                    last_pitch_reg   <= new_pitch_reg;
                    last_roll_reg    <= new_roll_reg;
                end
                default: ;
            endcase
        end
    end

    assign status.sq_done     = (sq_bit_reg == '0);
    assign status.cordic_done = (ci_reg == 5'(Steps));
    assign pitch_deg = new_pitch_reg;
    assign roll_deg  = new_roll_reg;
    assign heading   = heading_reg;

endmodule

// ===== src/tcc_ctrl.sv =====
// Compass sequencer: walks isqrt, CORDIC and product steps for one word.
// Depends on tcc_pkg.
module tcc_ctrl import tcc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic    s_command,
    output logic    m_valid,
    input  logic    m_ready,
    output cmd_t    cmd,
    output logic    zero_heading,
    input  status_t status
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_INIT, S_SQ, S_VEC_INIT, S_VEC, S_TILT,
        S_ROT_INIT, S_ROT, S_ROT_DONE, S_MUL, S_YFIX, S_HVEC, S_HEAD, S_OUT
    } state_t;

    state_t     state_reg;
    logic       sel_reg, armed_reg;
    logic [2:0] mstep_reg;

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = (state_reg == S_OUT);
    assign zero_heading = s_valid && s_ready && (s_command == CmdZero);

    always_comb begin
        cmd.sel   = sel_reg;
        cmd.mstep = mstep_reg;
        unique case (state_reg)
            S_IDLE:     cmd.op = (s_valid && s_command == CmdSample && armed_reg)
                                 ? OP_LOAD : OP_NONE;
            S_SQ_INIT:  cmd.op = OP_SQ_INIT;
            S_SQ:       cmd.op = status.sq_done ? OP_NONE : OP_SQ_STEP;
            S_VEC_INIT: cmd.op = OP_VEC_INIT;
            S_VEC:      cmd.op = status.cordic_done ? OP_NONE : OP_VEC_STEP;
            S_TILT:     cmd.op = OP_TILT_DONE;
            S_ROT_INIT: cmd.op = OP_ROT_INIT;
            S_ROT:      cmd.op = status.cordic_done ? OP_NONE : OP_ROT_STEP;
            S_ROT_DONE: cmd.op = OP_ROT_DONE;
            S_MUL:      cmd.op = OP_MUL;
            S_YFIX:     cmd.op = OP_HEAD_INIT;
            S_HVEC:     cmd.op = OP_VEC_INIT;
            S_HEAD:     cmd.op = OP_HEAD_DONE;
            S_OUT:      cmd.op = OP_NONE;
            default:    cmd.op = OP_NONE;
        endcase
        if (state_reg == S_HVEC) cmd.mstep = 3'd7;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
            armed_reg <= 1'b0;
            mstep_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_valid && s_command == CmdSample) begin
                    if (armed_reg) begin
                        state_reg <= S_SQ_INIT;
                        sel_reg   <= 1'b0;
                    end
                    armed_reg <= 1'b1;
                end
                S_SQ_INIT: state_reg <= S_SQ;
                S_SQ:      if (status.sq_done) state_reg <= S_VEC_INIT;
                S_VEC_INIT: state_reg <= S_VEC;
                S_VEC:     if (status.cordic_done) state_reg <= S_TILT;
                S_TILT: begin
                    sel_reg   <= ~sel_reg;
                    state_reg <= sel_reg ? S_ROT_INIT : S_SQ_INIT;
                end
                S_ROT_INIT: state_reg <= S_ROT;
                S_ROT:     if (status.cordic_done) state_reg <= S_ROT_DONE;
                S_ROT_DONE: begin
                    sel_reg <= ~sel_reg;
                    mstep_reg <= '0;
                    state_reg <= sel_reg ? S_MUL : S_ROT_INIT;
                end
                S_MUL: begin
                    mstep_reg <= mstep_reg + 3'd1;
                    if (mstep_reg == 3'd6) state_reg <= S_YFIX;
                end
                S_YFIX:    state_reg <= S_HVEC;
                S_HVEC:    state_reg <= S_VEC;
                S_OUT:     if (m_ready) state_reg <= S_IDLE;
                S_HEAD:    state_reg <= S_OUT;
                default:   state_reg <= S_IDLE;
            endcase
            if (state_reg == S_VEC && status.cordic_done && mstep_reg == 3'd7)
                state_reg <= S_HEAD;
            if (state_reg == S_HVEC) mstep_reg <= 3'd7;
            if (state_reg == S_HEAD) mstep_reg <= '0;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready)
        else $error("result while accepting");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_HEAD) |=> m_valid)
        else $error("heading not shown");

endmodule

// ===== src/tilt_compensated_compass.sv =====
// Tilt-compensated compass top level: sequencer plus datapath.
// Depends on tcc_pkg, tcc_ctrl, tcc_datapath.
// Each CORDIC pass runs Steps = min(CORDIC_STEPS, 24) iterations; words are handled one at a
// time, each sample taking two isqrt passes and five CORDIC passes through one shared unit.
// No new word is taken until the result is accepted. Zero-heading words and the first sample
// after reset give no result; reset clears control state, trims, heading offset and last angles.
module tilt_compensated_compass import tcc_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic signed [15:0] s_accel_x,
    input  logic signed [15:0] s_accel_y,
    input  logic signed [15:0] s_accel_z,
    input  logic signed [15:0] s_mag_x,
    input  logic signed [15:0] s_mag_y,
    input  logic signed [15:0] s_mag_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [8:0]  m_pitch_deg,
    output logic signed [8:0]  m_roll_deg,
    output logic signed [15:0] m_heading,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    cmd_t    cmd;
    status_t status;
    logic    zero_heading;

    tcc_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command,
        .m_valid, .m_ready, .cmd, .zero_heading, .status
    );

    tcc_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .aclk, .aresetn, .cmd, .status,
        .accel_x(s_accel_x), .accel_y(s_accel_y), .accel_z(s_accel_z),
        .mag_x(s_mag_x), .mag_y(s_mag_y), .mag_z(s_mag_z),
        .zero_heading, .cfg_we, .cfg_index, .cfg_data,
        .pitch_deg(m_pitch_deg), .roll_deg(m_roll_deg), .heading(m_heading)
    );

endmodule

// ===== tb/tb_tilt_compensated_compass.sv =====
// Self-checking testbench for the tilt-compensated compass: a queue-fed driver,
// a checking monitor and a bit-accurate fixed-point predictor of pitch, roll and heading.
// Depends on tcc_pkg and tilt_compensated_compass.
`timescale 1ns / 1ps

module tb_tilt_compensated_compass;
    import tcc_pkg::*;

    localparam int NSTEPS = 16;
    localparam logic [31:0] ATAN [0:23] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };
    localparam longint ROT_START = 64'd652032874;
    localparam logic [31:0] DEG_UNITS = 32'd11930465;
    localparam int SETTLE = 400;
    localparam int HOLD_AFTER = 450;

    typedef struct packed {
        logic        cmd;
        logic [15:0] ax, ay, az, mx, my, mz;
    } sample_t;

    typedef struct packed {
        logic [8:0]  pitch;
        logic [8:0]  roll;
        logic [15:0] heading;
    } attitude_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_command = CmdSample;
    logic signed [15:0] s_accel_x = '0, s_accel_y = '0, s_accel_z = '0;
    logic signed [15:0] s_mag_x = '0, s_mag_y = '0, s_mag_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [8:0] m_pitch_deg, m_roll_deg;
    logic signed [15:0] m_heading;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = RegPitchTrim;
    logic [15:0] cfg_data = '0;

    tilt_compensated_compass u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_accel_x(s_accel_x), .s_accel_y(s_accel_y), .s_accel_z(s_accel_z),
        .s_mag_x(s_mag_x), .s_mag_y(s_mag_y), .s_mag_z(s_mag_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pitch_deg(m_pitch_deg), .m_roll_deg(m_roll_deg), .m_heading(m_heading),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sample_t   pending_words[$];
    attitude_t expected_att[$];
    int        errors = 0;
    bit        idle_on = 1'b1;
    int        tx_gap = 0;
    int        rx_gap = 0;
    int        rx_hold = 0;
    int        rx_words = 0;
    bit        hold_done = 1'b0;

    bit          armed = 1'b0;
    int          prev_pitch = 0, prev_roll = 0;
    logic [15:0] prev_heading = '0, heading_zero = '0;
    int          pitch_trim = 0, roll_trim = 0;

    function automatic longint unsigned isqrt64(longint unsigned n);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] atan2_bau(longint y, longint x);
        logic [31:0] z = '0;
        logic [31:0] t;
        longint nx, ny;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < NSTEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN[i];
            end
            x = nx;
            y = ny;
        end
        t = z + 32'h8000;
        return t[31:16];
    endfunction

    task automatic sin_cos(input int deg, output longint c, output longint s);
        logic [31:0] z;
        bit flip;
        longint x, y, nx, ny;
        z = 32'(deg) * DEG_UNITS;
        flip = (z[31:30] == 2'd1 || z[31:30] == 2'd2);
        x = ROT_START;
        y = 0;
        if (flip) z -= 32'h80000000;
        for (int i = 0; i < NSTEPS; i++) begin
            if (!z[31]) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z -= ATAN[i];
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z += ATAN[i];
            end
            x = nx;
            y = ny;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic int tilt_degrees(longint a, longint b, longint c, int trim);
        longint unsigned sq;
        longint r, v, m, d;
        logic [15:0] ang;
        sq = longint'(b * b + c * c) << 16;
        r = longint'(isqrt64(sq));
        ang = atan2_bau(a * 256, r);
        v = longint'($signed(ang)) - trim;
        m = (v < 0) ? -v : v;
        d = (m * 45 + 4096) >>> 13;
        if (d > 180) d = 180;
        return int'((v < 0) ? -d : d);
    endfunction

    task automatic predict_attitude(input sample_t w);
        longint ax, ay, az, mx, my, mz, cp, sp, cr, sr, xh, yh;
        int p, r;
        logic [15:0] raw;
        attitude_t e;
        if (w.cmd == CmdZero) begin
            heading_zero = prev_heading;
            return;
        end
        if (!armed) begin
            armed = 1'b1;
            return;
        end
        ax = $signed(w.ax); ay = $signed(w.ay); az = $signed(w.az);
        mx = $signed(w.mx); my = $signed(w.my); mz = $signed(w.mz);
        p = tilt_degrees(ax, ay, az, pitch_trim);
        r = tilt_degrees(ay, ax, az, roll_trim);
        sin_cos(prev_pitch, cp, sp);
        sin_cos(prev_roll, cr, sr);
        xh = mx * cp + mz * sp;
        yh = mx * ((sr * sp) >>> 30) + my * cr - mz * ((sr * cp) >>> 30);
        raw = atan2_bau(-(yh >>> 14), xh >>> 14);
        e.pitch = 9'(p);
        e.roll = 9'(r);
        e.heading = raw - heading_zero;
        prev_pitch = p;
        prev_roll = r;
        prev_heading = raw;
        expected_att.push_back(e);
    endtask

    // hold valid and payload until accepted; predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            sample_t w;
            if (s_valid)
                predict_attitude({s_command, s_accel_x, s_accel_y, s_accel_z,
                                  s_mag_x, s_mag_y, s_mag_z});
            if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
                s_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                tx_gap <= $urandom_range(0, 13);
                s_valid <= 1'b0;
            end else begin
                w = pending_words.pop_front();
                s_command <= w.cmd;
                s_accel_x <= w.ax; s_accel_y <= w.ay; s_accel_z <= w.az;
                s_mag_x <= w.mx; s_mag_y <= w.my; s_mag_z <= w.mz;
                s_valid <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && rx_words >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            rx_hold <= 2999;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_gap <= $urandom_range(0, 13);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            attitude_t e;
            rx_words <= rx_words + 1;
            if (expected_att.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: pitch %0d roll %0d heading %0d",
                             m_pitch_deg, m_roll_deg, m_heading);
            end else begin
                e = expected_att.pop_front();
                if (m_pitch_deg !== e.pitch || m_roll_deg !== e.roll
                        || m_heading !== e.heading) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                 $signed(e.pitch), $signed(e.roll), $signed(e.heading),
                                 m_pitch_deg, m_roll_deg, m_heading);
                end
            end
        end
    end

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t any_sample(logic c);
        sample_t w;
        w.cmd = c;
        w.ax = pick16(); w.ay = pick16(); w.az = pick16();
        w.mx = pick16(); w.my = pick16(); w.mz = pick16();
        return w;
    endfunction

    function automatic sample_t fixed_sample(logic [15:0] ax, ay, az, mx, my, mz);
        return '{CmdSample, ax, ay, az, mx, my, mz};
    endfunction

    task automatic wait_idle();
        wait (pending_words.size() == 0 && !s_valid && expected_att.size() == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_trim(logic [0:0] idx, int val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == RegPitchTrim) pitch_trim = val;
        else roll_trim = val;
        @(posedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_trim(RegPitchTrim, 0);
        write_trim(RegRollTrim, 0);

        pending_words.push_back(any_sample(CmdZero));
        pending_words.push_back(fixed_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 2, 3));
        pending_words.push_back(fixed_sample(0, 0, 0, 0, 0, 0));
        pending_words.push_back(fixed_sample(16'h7FFF, 0, 0, 16'h7FFF, 0, 0));
        pending_words.push_back(fixed_sample(16'h8000, 0, 0, 16'h8000, 0, 0));
        pending_words.push_back(fixed_sample(0, 16'h7FFF, 0, 0, 16'h7FFF, 0));
        pending_words.push_back(fixed_sample(0, 16'h8000, 0, 0, 16'h8000, 0));
        pending_words.push_back(fixed_sample(0, 0, 16'h7FFF, 0, 0, 16'h7FFF));
        pending_words.push_back(fixed_sample(16'h8000, 16'h8000, 16'h8000,
                                             16'h8000, 16'h8000, 16'h8000));
        pending_words.push_back(fixed_sample(16'h7FFF, 16'h8000, 16'h7FFF,
                                             16'h7FFF, 16'h7FFF, 16'h8000));
        pending_words.push_back(any_sample(CmdZero));
        pending_words.push_back(fixed_sample(100, -200, 16000, 300, -400, 500));
        pending_words.push_back(fixed_sample(0, 0, 0, 0, 0, 0));

        write_trim(RegPitchTrim, -16384);
        write_trim(RegRollTrim, 16384);
        pending_words.push_back(fixed_sample(16'h7FFF, 16'h8000, 0, 5, 6, 7));
        pending_words.push_back(fixed_sample(16'h8000, 16'h7FFF, 0, -5, 6, -7));
        pending_words.push_back(fixed_sample(0, 0, 1000, 1000, 0, 0));
        write_trim(RegPitchTrim, 16384);
        write_trim(RegRollTrim, -16384);
        pending_words.push_back(fixed_sample(16'h8000, 16'h7FFF, 0, 5, 6, 7));
        pending_words.push_back(fixed_sample(16'h7FFF, 16'h8000, 0, -5, 6, -7));
        pending_words.push_back(any_sample(CmdZero));
        pending_words.push_back(fixed_sample(10, 10, 10, 10, 10, 10));

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_trim(RegPitchTrim, 0); write_trim(RegRollTrim, 0); end
                1: begin write_trim(RegPitchTrim, -16384); write_trim(RegRollTrim, 16384); end
                4: begin write_trim(RegPitchTrim, 16384); write_trim(RegRollTrim, -16384); end
                default: begin
                    write_trim(RegPitchTrim, $urandom_range(0, 32768) - 16384);
                    write_trim(RegRollTrim, $urandom_range(0, 32768) - 16384);
                end
            endcase
            if (ph == 4) idle_on = 1'b0;
            for (int k = 0; k < 200; k++)
                pending_words.push_back(any_sample($urandom_range(0, 11) == 0));
        end

        wait_idle();
        if (errors == 0 && expected_att.size() == 0)
            $display("tb_tilt_compensated_compass passed");
        else
            $display("tb_tilt_compensated_compass failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_tilt_compensated_compass failed");
        $finish;
    end

endmodule
